// File: src/q2e_pkg.sv
package q2e_pkg;

  localparam int unsigned OPW       = 36;  // product terms and CORDIC vector
  localparam int unsigned ANGW      = 34;  // angle accumulator, Q.30
  localparam int unsigned SQRT_BITS = 29;  // root bits of a value up to 2^56
  localparam int unsigned RADW      = 58;  // radicand and remainder width
  localparam int unsigned TERM_LAT  = 3;   // products, terms, radicand multiply

  localparam logic signed [OPW-1:0]  ONE_Q28     = OPW'(64'sd268435456);
  localparam logic signed [OPW-1:0]  NEG_ONE_Q28 = -OPW'(64'sd268435456);
  localparam logic signed [ANGW-1:0] HALF_PI_Q30 = ANGW'(64'sd1686629713);
  localparam logic signed [ANGW:0]   ROUND_Q30   = (ANGW+1)'(64'sd65536);

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  typedef struct packed {
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] pitch_y;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
  } terms_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ANGW-1:0] atan_entry(input int unsigned idx);
    logic signed [ANGW-1:0] v;
    case (idx)
      0:  v = ANGW'(64'sd843314856);
      1:  v = ANGW'(64'sd497837829);
      2:  v = ANGW'(64'sd263043836);
      3:  v = ANGW'(64'sd133525158);
      4:  v = ANGW'(64'sd67021686);
      5:  v = ANGW'(64'sd33543515);
      6:  v = ANGW'(64'sd16775850);
      7:  v = ANGW'(64'sd8388437);
      8:  v = ANGW'(64'sd4194282);
      9:  v = ANGW'(64'sd2097149);
      10: v = ANGW'(64'sd1048575);
      11: v = ANGW'(64'sd524287);
      12: v = ANGW'(64'sd262143);
      13: v = ANGW'(64'sd131071);
      14: v = ANGW'(64'sd65535);
      15: v = ANGW'(64'sd32767);
      16: v = ANGW'(64'sd16383);
      17: v = ANGW'(64'sd8191);
      18: v = ANGW'(64'sd4095);
      19: v = ANGW'(64'sd2047);
      20: v = ANGW'(64'sd1023);
      21: v = ANGW'(64'sd511);
      22: v = ANGW'(64'sd255);
      23: v = ANGW'(64'sd127);
      24: v = ANGW'(64'sd63);
      25: v = ANGW'(64'sd31);
      26: v = ANGW'(64'sd15);
      27: v = ANGW'(64'sd7);
      28: v = ANGW'(64'sd3);
      29: v = ANGW'(64'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/quaternion_to_euler_angles_unit.sv
// Quaternion to roll, pitch and yaw. One Q1.14 quaternion request enters per
// clock and one Q2.13 result in radians leaves per clock while the pipeline is
// not held. The stages are the products, the terms and the pitch radicand,
// then the one-bit-per-stage square root on the pitch path (the roll and yaw
// operands wait alongside it), then one quarter-turn stage, CORDIC_STAGES
// vectoring stages and one rounding stage in three parallel CORDIC pipelines.
// The whole pipeline holds while a result waits on out_ready; a request is
// taken in the cycle the pipeline advances.
module quaternion_to_euler_angles_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  q2e_pkg::quat_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output q2e_pkg::euler_t  out_data
);
  import q2e_pkg::*;

  localparam int unsigned DLY = 1 + SQRT_BITS;
  localparam int unsigned LAT = TERM_LAT + SQRT_BITS + CORDIC_STAGES + 2;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign out_valid = vld_r[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: products, Q.28
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_data.quat_w * in_data.quat_x;
      yz_r <= in_data.quat_y * in_data.quat_z;
      xx_r <= in_data.quat_x * in_data.quat_x;
      yy_r <= in_data.quat_y * in_data.quat_y;
      wy_r <= in_data.quat_w * in_data.quat_y;
      zx_r <= in_data.quat_z * in_data.quat_x;
      wz_r <= in_data.quat_w * in_data.quat_z;
      xy_r <= in_data.quat_x * in_data.quat_y;
      zz_r <= in_data.quat_z * in_data.quat_z;
    end
  end

  // stage 2: atan2 operands, pitch term clamped to [-1, +1]
  terms_t                terms_nxt;
  terms_t                terms_r;
  logic signed [OPW-1:0] pitch_raw;

  always_comb begin
    terms_nxt.roll_y = (OPW'(wx_r) + OPW'(yz_r)) <<< 1;
    terms_nxt.roll_x = ONE_Q28 - ((OPW'(xx_r) + OPW'(yy_r)) <<< 1);
    terms_nxt.yaw_y  = (OPW'(wz_r) + OPW'(xy_r)) <<< 1;
    terms_nxt.yaw_x  = ONE_Q28 - ((OPW'(yy_r) + OPW'(zz_r)) <<< 1);
    pitch_raw        = (OPW'(wy_r) - OPW'(zx_r)) <<< 1;
    if (pitch_raw > ONE_Q28) begin
      terms_nxt.pitch_y = ONE_Q28;
    end else if (pitch_raw < NEG_ONE_Q28) begin
      terms_nxt.pitch_y = NEG_ONE_Q28;
    end else begin
      terms_nxt.pitch_y = pitch_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  // stage 3: radicand (1 - t)(1 + t), both factors within [0, 2]
  logic [29:0]     fac_lo, fac_hi;
  logic [59:0]     rad_full;
  logic [RADW-1:0] rad_r;

  assign fac_lo   = 30'(ONE_Q28 - terms_r.pitch_y);
  assign fac_hi   = 30'(ONE_Q28 + terms_r.pitch_y);
  assign rad_full = fac_lo * fac_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_full[RADW-1:0];
    end
  end

  logic [SQRT_BITS-1:0] root;

  q2e_sqrt_pipe u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (rad_r),
    .root_o (root)
  );

  // hold the other operands level with the square root
  terms_t dly_r [0:DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= terms_r;
      for (int unsigned i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  terms_t                op;
  logic signed [OPW-1:0] root_ext;

  assign op       = dly_r[DLY-1];
  assign root_ext = OPW'(root);

  logic signed [15:0] roll_a, pitch_a, yaw_a;

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk     (clk),
    .en      (en),
    .y_i     (op.roll_y),
    .x_i     (op.roll_x),
    .angle_o (roll_a)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk     (clk),
    .en      (en),
    .y_i     (op.pitch_y),
    .x_i     (root_ext),
    .angle_o (pitch_a)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk     (clk),
    .en      (en),
    .y_i     (op.yaw_y),
    .x_i     (op.yaw_x),
    .angle_o (yaw_a)
  );

  assign out_data.roll  = roll_a;
  assign out_data.pitch = pitch_a;
  assign out_data.yaw   = yaw_a;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request taken while the pipeline is held");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// File: src/q2e_sqrt_pipe.sv
module q2e_sqrt_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [q2e_pkg::RADW-1:0]      rad_i,
  output logic [q2e_pkg::SQRT_BITS-1:0] root_o
);
  import q2e_pkg::*;

  logic [RADW-1:0] rem_r [1:SQRT_BITS];
  logic [RADW-1:0] res_r [1:SQRT_BITS];

  // one root bit per stage, highest first; the radicand feeds the first stage directly
  for (genvar s = 0; s < SQRT_BITS; s++) begin : g_stage
    localparam logic [RADW-1:0] BIT = RADW'(1) << (2 * (SQRT_BITS - 1 - s));
    logic [RADW-1:0] rem_cur;
    logic [RADW-1:0] res_cur;
    logic [RADW-1:0] trial;
    logic [RADW-1:0] rem_nxt;
    logic [RADW-1:0] res_nxt;

    if (s == 0) begin : g_first
      assign rem_cur = rad_i;
      assign res_cur = '0;
    end else begin : g_next
      assign rem_cur = rem_r[s];
      assign res_cur = res_r[s];
    end

    always_comb begin
      trial = res_cur + BIT;
      if (rem_cur >= trial) begin
        rem_nxt = rem_cur - trial;
        res_nxt = (res_cur >> 1) + BIT;
      end else begin
        rem_nxt = rem_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        res_r[s+1] <= res_nxt;
      end
    end
  end

  assign root_o = res_r[SQRT_BITS][SQRT_BITS-1:0];

endmodule

// File: src/q2e_cordic.sv
module q2e_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [q2e_pkg::OPW-1:0]   y_i,
  input  logic signed [q2e_pkg::OPW-1:0]   x_i,
  output logic signed [15:0]               angle_o
);
  import q2e_pkg::*;

  logic signed [OPW-1:0]  x_r [0:STAGES];
  logic signed [OPW-1:0]  y_r [0:STAGES];
  logic signed [ANGW-1:0] z_r [0:STAGES];
  logic                   zero_r [0:STAGES];
  logic signed [15:0]     angle_r;

  // turn a left half-plane vector by a quarter turn first
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_r[0] <= y_i;
          y_r[0] <= -x_i;
          z_r[0] <= HALF_PI_Q30;
        end else begin
          x_r[0] <= -y_i;
          y_r[0] <= x_i;
          z_r[0] <= -HALF_PI_Q30;
        end
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ANGW-1:0] ATAN = atan_entry(s);
    logic signed [OPW-1:0] xs;
    logic signed [OPW-1:0] ys;

    assign xs = x_r[s] >>> s;
    assign ys = y_r[s] >>> s;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[s+1] <= zero_r[s];
        if (y_r[s] >= 0) begin
          x_r[s+1] <= x_r[s] + ys;
          y_r[s+1] <= y_r[s] - xs;
          z_r[s+1] <= z_r[s] + ATAN;
        end else begin
          x_r[s+1] <= x_r[s] - ys;
          y_r[s+1] <= y_r[s] + xs;
          z_r[s+1] <= z_r[s] - ATAN;
        end
      end
    end
  end

  // round Q.30 to Q2.13 and saturate; a zero vector gives a zero angle
  logic signed [ANGW:0]    z_rnd;
  logic signed [ANGW-17:0] z_q13;
  logic signed [15:0]      angle_nxt;

  always_comb begin
    z_rnd = (ANGW+1)'(z_r[STAGES]) + ROUND_Q30;
    z_q13 = z_rnd[ANGW:17];
    if (zero_r[STAGES]) begin
      angle_nxt = '0;
    end else if (z_q13 > (ANGW-16)'(32767)) begin
      angle_nxt = 16'sh7FFF;
    end else if (z_q13 < -(ANGW-16)'(32768)) begin
      angle_nxt = -16'sh8000;
    end else begin
      angle_nxt = z_q13[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule
